[sv/csa_pkg.sv]
package csa_pkg;

  localparam logic [63:0] GOLDEN_STEP   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_ONE       = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_TWO       = 64'h94d049bb133111eb;
  localparam logic [63:0] SIGN_KEY_SALT = 64'h7f4a7c159e3779b9;
  localparam int          SIGN_BIT      = 63;

  localparam logic CFG_SKETCH_KEY   = 1'b0;
  localparam logic CFG_BUCKET_COUNT = 1'b1;

  localparam logic [10:0] COUNT_RESET = 11'd1000;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  typedef struct packed {
    logic               command;
    logic        [31:0] column_index;
    logic signed [31:0] element_value;
    logic        [9:0]  read_bucket;
  } in_t;

  typedef struct packed {
    logic signed [31:0] bucket_sum;
    logic               sum_saturated;
  } out_t;

  typedef enum logic [1:0] {
    MIX_KEY  = 2'd0,
    MIX_SALT = 2'd1,
    MIX_COLB = 2'd2,
    MIX_COLS = 2'd3
  } mix_src_t;

  typedef enum logic [1:0] {
    ADDR_CLR  = 2'd0,
    ADDR_SLOT = 2'd1,
    ADDR_RB   = 2'd2
  } addr_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      mix_start;
    mix_src_t  mix_src;
    logic      key_start;
    logic      cap_bkey;
    logic      cap_skey;
    logic      cap_sign;
    logic      mod_start;
    addr_sel_t addr_sel;
    logic      ram_re;
    logic      ram_we;
    logic      wr_zero;
    logic      clr_step;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_cmd;
    logic in_zero;
    logic key_dirty;
    logic mix_busy;
    logic mod_busy;
    logic beyond;
    logic clr_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

[sv/csa_ram.sv]
module csa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/csa_mix.sv]
module csa_mix import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        busy,
  output logic [63:0] result
);

  // One 32x32 partial product per cycle; the product is kept modulo 2^64.
  logic [63:0] z;
  logic [63:0] acc;
  logic [3:0]  cnt;
  logic [63:0] k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  assign k     = (cnt < 4'd6) ? MIX_ONE : MIX_TWO;
  assign mul_a = (cnt == 4'd4 || cnt == 4'd8) ? z[63:32] : z[31:0];
  assign mul_b = (cnt == 4'd3 || cnt == 4'd7) ? k[63:32] : k[31:0];
  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};
  assign result = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd1;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'd9) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z <= din + GOLDEN_STEP;
    end else if (busy) begin
      case (cnt)
        4'd1: z <= z ^ (z >> 30);
        4'd2, 4'd6: acc <= prod;
        4'd3, 4'd4, 4'd7, 4'd8: acc <= acc + {prod[31:0], 32'b0};
        4'd5: z <= acc ^ (acc >> 27);
        4'd9: z <= acc ^ (acc >> 31);
        default: z <= z;
      endcase
    end
  end

endmodule

[sv/csa_mod.sv]
module csa_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [10:0] divisor,
  output logic        busy,
  output logic [10:0] rem
);

  // Restoring remainder, one dividend bit per cycle, most significant first.
  logic [63:0] shreg;
  logic [10:0] dvs;
  logic [6:0]  cnt;
  logic [11:0] trial;

  assign trial = {rem, shreg[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= 11'd0;
    end else if (busy) begin
      shreg <= {shreg[62:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= 11'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[10:0];
      end
    end
  end

endmodule

[sv/csa_datapath.sv]
module csa_datapath import csa_pkg::*; #(
  parameter int MAX_BUCKETS = 1024,
  parameter int AW = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  in_t        in_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [63:0] cfg_data,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t st,
  input  logic       out_stall,
  output logic       out_valid,
  output out_t       out_data
);

  localparam int CAP = (MAX_BUCKETS < 2047) ? MAX_BUCKETS : 2047;

  logic [63:0] sketch_key;
  logic [10:0] bucket_count;
  logic        key_dirty;
  logic [63:0] bucket_key;
  logic [63:0] sign_key;
  logic        sign_pos;

  logic [31:0]        column;
  logic signed [31:0] value;
  logic [9:0]         rb;

  logic [10:0] eff_count;
  logic [63:0] mix_din;
  logic        mix_busy;
  logic [63:0] mix_res;
  logic        mod_busy;
  logic [10:0] mod_rem;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] addr;
  logic [32:0]   ram_wdata;
  logic [32:0]   ram_rdata;

  logic signed [33:0] val_ext;
  logic signed [33:0] total;
  logic signed [31:0] new_sum;
  logic               new_clip;
  logic               beyond;

  always_comb begin
    eff_count = bucket_count;
    if (bucket_count == 11'd0) begin
      eff_count = 11'd1;
    end else if (int'(bucket_count) > CAP) begin
      eff_count = 11'(CAP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sketch_key   <= 64'd0;
      bucket_count <= COUNT_RESET;
      key_dirty    <= 1'b1;
    end else begin
      if (cmd.key_start) begin
        key_dirty <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SKETCH_KEY: begin
            sketch_key <= cfg_data;
            key_dirty  <= 1'b1;
          end
          CFG_BUCKET_COUNT: bucket_count <= cfg_data[10:0];
          default: bucket_count <= bucket_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_bkey) begin
      bucket_key <= mix_res;
    end
    if (cmd.cap_skey) begin
      sign_key <= mix_res;
    end
    if (cmd.cap_sign) begin
      sign_pos <= mix_res[SIGN_BIT];
    end
    if (cmd.load_item) begin
      column <= in_data.column_index;
      value  <= in_data.element_value;
      rb     <= in_data.read_bucket;
    end
  end

  always_comb begin
    case (cmd.mix_src)
      MIX_KEY:  mix_din = sketch_key;
      MIX_SALT: mix_din = sketch_key ^ SIGN_KEY_SALT;
      MIX_COLB: mix_din = {32'd0, column} ^ bucket_key;
      MIX_COLS: mix_din = {32'd0, column} ^ sign_key;
      default:  mix_din = sketch_key;
    endcase
  end

  csa_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mix_start),
    .din    (mix_din),
    .busy   (mix_busy),
    .result (mix_res)
  );

  csa_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mix_res),
    .divisor  (eff_count),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_CLR:  addr = clr_addr;
      ADDR_SLOT: addr = AW'(mod_rem);
      ADDR_RB:   addr = AW'(rb);
      default:   addr = clr_addr;
    endcase
  end

  // Saturating update of the bucket that was just read.
  assign val_ext = {{2{value[31]}}, value};
  assign total   = {{2{ram_rdata[31]}}, ram_rdata[31:0]} + (sign_pos ? val_ext : -val_ext);

  always_comb begin
    new_sum  = total[31:0];
    new_clip = ram_rdata[32];
    if (total > 34'sd2147483647) begin
      new_sum  = 32'sh7fffffff;
      new_clip = 1'b1;
    end else if (total < -34'sd2147483648) begin
      new_sum  = 32'sh80000000;
      new_clip = 1'b1;
    end
  end

  assign ram_wdata = cmd.wr_zero ? 33'd0 : {new_clip, new_sum};

  csa_ram #(.WIDTH(33), .DEPTH(MAX_BUCKETS)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (cmd.ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign beyond = ({1'b0, rb} >= eff_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (beyond) begin
        out_data <= '0;
      end else begin
        out_data.bucket_sum    <= ram_rdata[31:0];
        out_data.sum_saturated <= ram_rdata[32];
      end
    end
  end

  assign st.in_cmd    = in_data.command;
  assign st.in_zero   = (in_data.element_value == 32'sd0);
  assign st.key_dirty = key_dirty;
  assign st.mix_busy  = mix_busy;
  assign st.mod_busy  = mod_busy;
  assign st.beyond    = beyond;
  assign st.clr_last  = (clr_addr == AW'(MAX_BUCKETS - 1));
  assign st.out_free  = !out_valid || !out_stall;

endmodule

[sv/csa_ctrl.sv]
module csa_ctrl import csa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ctrl_stat_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLR    = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_KEY_A  = 11'b00000000100,
    S_KEY_B  = 11'b00000001000,
    S_ACC_GO = 11'b00000010000,
    S_HASH_B = 11'b00000100000,
    S_HASH_S = 11'b00001000000,
    S_MOD_W  = 11'b00010000000,
    S_ACC_WR = 11'b00100000000,
    S_RD_RD  = 11'b01000000000,
    S_RD_OUT = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = !(state == S_IDLE && !st.key_dirty);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mix_src  = MIX_KEY;
    cmd.addr_sel = ADDR_CLR;
    case (state)
      S_CLR: begin
        cmd.ram_we   = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (st.key_dirty) begin
          cmd.key_start = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_src   = MIX_KEY;
          state_next    = S_KEY_A;
        end else if (accept) begin
          cmd.load_item = 1'b1;
          if (st.in_cmd == CMD_READ) begin
            state_next = S_RD_RD;
          end else if (!st.in_zero) begin
            state_next = S_ACC_GO;
          end
        end
      end
      S_KEY_A: begin
        if (!st.mix_busy) begin
          cmd.cap_bkey  = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_src   = MIX_SALT;
          state_next    = S_KEY_B;
        end
      end
      S_KEY_B: begin
        if (!st.mix_busy) begin
          cmd.cap_skey = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ACC_GO: begin
        cmd.mix_start = 1'b1;
        cmd.mix_src   = MIX_COLB;
        state_next    = S_HASH_B;
      end
      S_HASH_B: begin
        if (!st.mix_busy) begin
          // The remainder unit latches the bucket hash as the sign hash starts.
          cmd.mod_start = 1'b1;
          cmd.mix_start = 1'b1;
          cmd.mix_src   = MIX_COLS;
          state_next    = S_HASH_S;
        end
      end
      S_HASH_S: begin
        if (!st.mix_busy) begin
          cmd.cap_sign = 1'b1;
          state_next   = S_MOD_W;
        end
      end
      S_MOD_W: begin
        cmd.addr_sel = ADDR_SLOT;
        if (!st.mod_busy) begin
          cmd.ram_re = 1'b1;
          state_next = S_ACC_WR;
        end
      end
      S_ACC_WR: begin
        cmd.addr_sel = ADDR_SLOT;
        cmd.ram_we   = 1'b1;
        state_next   = S_IDLE;
      end
      S_RD_RD: begin
        cmd.addr_sel = ADDR_RB;
        cmd.ram_re   = 1'b1;
        state_next   = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.addr_sel = ADDR_RB;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ram_we   = !st.beyond;
          cmd.wr_zero  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/count_sketch_accumulator.sv]
// Count sketch accumulator for one matrix row.
// Input channel (in_valid / in_stall / in_data) takes one beat per element or
// read request; output channel (out_valid / out_stall / out_data) gives one
// beat per read request and none for an accumulate.
// Configuration: cfg_we with cfg_index 0 writes the 64-bit sketch key, index 1
// the bucket count. A new key is hashed into the bucket and sign keys before
// the next beat is taken.
// An accumulate with a nonzero value takes two splitmix64 passes in the shared
// mixer and a bit-serial remainder by the bucket count, then a read and write
// of the bucket RAM. A zero value is accepted and dropped. A read passes a RAM
// read state, then an output state that waits for a free output register and
// there loads its beat and clears the bucket (unless beyond the count).
// After reset the bucket RAM is cleared one entry per cycle, followed by key
// derivation; in_stall stays high throughout.
// When the receiver stalls, the result stays in the output register; the next
// beat is still accepted, and a later read waits until the register frees up.
module count_sketch_accumulator import csa_pkg::*; #(
  parameter int MAX_BUCKETS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  ctrl_cmd_t  cmd;
  ctrl_stat_t st;

  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  csa_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .AW(AW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result beat appeared without a load");
  a_mix_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mix_start |-> !st.mix_busy)
    else $error("mixer restarted while busy");
  a_mod_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> !st.mod_busy)
    else $error("remainder unit restarted while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten");
`endif

endmodule

[tb/tb_count_sketch_accumulator.sv]
module tb_count_sketch_accumulator;
  import csa_pkg::*;

  localparam int  NUM_BUCKETS = 1024;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  LONG_HOLD   = 300;

  class bucket_ledger;
    logic signed [31:0] sums [NUM_BUCKETS];
    logic               clipped [NUM_BUCKETS];
    logic [63:0]        bucket_key;
    logic [63:0]        sign_key;
    logic [10:0]        count_reg;
    out_t               pending_reads [$];
    int                 errors;
    int                 reads_seen;
    int                 clip_reads;

    function new();
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        sums[i] = '0;
        clipped[i] = 1'b0;
      end
      errors = 0;
      reads_seen = 0;
      clip_reads = 0;
      count_reg = COUNT_RESET;
      set_key(64'd0);
    endfunction

    function logic [63:0] splitmix(logic [63:0] seed);
      logic [63:0] z;
      z = seed + GOLDEN_STEP;
      z = (z ^ (z >> 30)) * MIX_ONE;
      z = (z ^ (z >> 27)) * MIX_TWO;
      return z ^ (z >> 31);
    endfunction

    function void set_key(logic [63:0] k);
      bucket_key = splitmix(k);
      sign_key = splitmix(k ^ SIGN_KEY_SALT);
    endfunction

    function int unsigned live_count();
      if (count_reg == 0) return 1;
      if (count_reg > NUM_BUCKETS) return NUM_BUCKETS;
      return count_reg;
    endfunction

    function void write_reg(logic idx, logic [63:0] data);
      if (idx == CFG_SKETCH_KEY) set_key(data);
      else count_reg = data[10:0];
    endfunction

    function void record_beat(in_t beat);
      logic [63:0] col;
      logic [63:0] slot;
      logic [63:0] sign_hash;
      longint      val;
      longint      total;
      out_t        res;
      col = {32'd0, beat.column_index};
      if (beat.command == CMD_ACCUMULATE) begin
        val = longint'($signed(beat.element_value));
        if (val == 0) return;
        slot = splitmix(col ^ bucket_key) % 64'(live_count());
        sign_hash = splitmix(col ^ sign_key);
        if (sign_hash[SIGN_BIT] == 1'b0) val = -val;
        total = longint'(sums[slot]) + val;
        if (total > 64'sd2147483647) begin
          total = 64'sd2147483647;
          clipped[slot] = 1'b1;
        end else if (total < -64'sd2147483648) begin
          total = -64'sd2147483648;
          clipped[slot] = 1'b1;
        end
        sums[slot] = total[31:0];
      end else begin
        if (beat.read_bucket >= live_count()) begin
          res.bucket_sum = '0;
          res.sum_saturated = 1'b0;
        end else begin
          res.bucket_sum = sums[beat.read_bucket];
          res.sum_saturated = clipped[beat.read_bucket];
          sums[beat.read_bucket] = '0;
          clipped[beat.read_bucket] = 1'b0;
        end
        pending_reads = {pending_reads, res};
      end
    endfunction

    function void compare_result(out_t got);
      out_t want;
      if (pending_reads.size() == 0) begin
        $error("result beat with nothing expected: sum %0d sat %0b",
               got.bucket_sum, got.sum_saturated);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      reads_seen++;
      if (want.sum_saturated) clip_reads++;
      if (got.bucket_sum !== want.bucket_sum) begin
        $error("bucket_sum: expected %0d, actual %0d", want.bucket_sum, got.bucket_sum);
        errors++;
      end
      if (got.sum_saturated !== want.sum_saturated) begin
        $error("sum_saturated: expected %0b, actual %0b",
               want.sum_saturated, got.sum_saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  bucket_ledger ledger;
  int           cycles;
  bit           no_gaps;
  bit           hold_request;
  logic [31:0]  column_pool [8];

  count_sketch_accumulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    ledger = new();
    cycles = 0;
    no_gaps = 1'b0;
    hold_request = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.compare_result(out_data);
  end

  // Receiver: a random stall before each result beat unless no_gaps is set, and on request one long hold-off.
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // The task returns at a falling edge with in_valid still high; the next beat or
  // wait_drained decides what the input shows at the coming rising edge.
  task automatic send_beat(in_t beat);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    ledger.record_beat(beat);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.pending_reads.size() != 0) @(negedge clk);
    // An accumulate may still be in flight after the last read has come back.
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    ledger.write_reg(idx, data);
    cfg_we <= 1'b0;
    cfg_data <= 64'($urandom());
  endtask

  task automatic accumulate(logic [31:0] col, logic [31:0] val);
    in_t b;
    b.command = CMD_ACCUMULATE;
    b.column_index = col;
    b.element_value = val;
    b.read_bucket = 10'($urandom());
    send_beat(b);
  endtask

  task automatic read_out(logic [9:0] bucket);
    in_t b;
    b.command = CMD_READ;
    b.column_index = $urandom();
    b.element_value = $urandom();
    b.read_bucket = bucket;
    send_beat(b);
  endtask

  task automatic random_phase(int items);
    in_t b;
    int  r;
    for (int i = 0; i < 8; i++) column_pool[i] = $urandom();
    for (int i = 0; i < items; i++) begin
      b.command = ($urandom_range(0, 99) < 25) ? CMD_READ : CMD_ACCUMULATE;
      b.column_index = ($urandom_range(0, 9) < 6) ? column_pool[$urandom_range(0, 7)]
                                                  : $urandom();
      r = $urandom_range(0, 9);
      if (r == 0) b.element_value = 32'sh7fffffff;
      else if (r == 1) b.element_value = 32'sh80000000;
      else if (r == 2) b.element_value = '0;
      else if (r < 6) b.element_value = $urandom();
      else b.element_value = $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
      if ($urandom_range(0, 9) < 8) begin
        b.read_bucket = 10'($urandom_range(0, ledger.live_count() - 1));
      end else begin
        b.read_bucket = 10'($urandom());
      end
      send_beat(b);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SKETCH_KEY;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    // The store is cleared after reset with the input held off.
    do @(negedge clk); while (in_stall);

    accumulate(32'd0, 32'sh7fffffff);
    accumulate(32'hffffffff, 32'sh80000000);
    accumulate(32'd5, 32'sd0);
    for (int i = 0; i < 4; i++) read_out(10'($urandom_range(0, 999)));
    read_out(10'd1023);
    read_out(10'd1000);
    read_out(10'd0);

    // With one bucket every element lands together; the same column repeats its sign.
    write_reg(CFG_BUCKET_COUNT, 64'd1);
    repeat (3) accumulate(32'd77, 32'sh80000000);
    accumulate(32'd78, 32'sd12345);
    read_out(10'd0);
    read_out(10'd0);
    read_out(10'd1);

    write_reg(CFG_BUCKET_COUNT, 64'd0);
    repeat (3) accumulate(32'd9, 32'sh7fffffff);
    read_out(10'd0);

    // Shrinking the count hides buckets without clearing them.
    write_reg(CFG_SKETCH_KEY, 64'hffffffffffffffff);
    write_reg(CFG_BUCKET_COUNT, 64'd2047);
    for (int i = 0; i < 6; i++) accumulate(32'(i), 32'(1000 + i));
    write_reg(CFG_BUCKET_COUNT, 64'd3);
    read_out(10'd900);
    write_reg(CFG_BUCKET_COUNT, 64'd1024);
    for (int i = 0; i < 4; i++) read_out(10'($urandom_range(0, 1023)));

    random_phase(220);
    write_reg(CFG_SKETCH_KEY, {$urandom(), $urandom()});
    write_reg(CFG_BUCKET_COUNT, 64'd1);
    random_phase(180);
    write_reg(CFG_BUCKET_COUNT, 64'd17);
    no_gaps = 1'b1;
    random_phase(150);
    no_gaps = 1'b0;

    // Hold off the receiver while reads keep arriving, so the block backs up.
    wait_drained();
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) read_out(10'($urandom_range(0, 16)));
    wait_drained();

    write_reg(CFG_SKETCH_KEY, 64'd0);
    write_reg(CFG_BUCKET_COUNT, 64'd2);
    random_phase(200);
    write_reg(CFG_SKETCH_KEY, {$urandom(), $urandom()});
    write_reg(CFG_BUCKET_COUNT, 64'($urandom_range(0, 2047)));
    random_phase(220);
    write_reg(CFG_BUCKET_COUNT, 64'd1000);
    random_phase(230);

    wait_drained();
    $display("Sketch run: %0d reads checked, %0d of them clipped, across several keys and counts.",
             ledger.reads_seen, ledger.clip_reads);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
